### design/nsm_pkg.sv
// shared types and constants of the naive string matcher
`default_nettype none

package nsm_pkg;

    localparam logic [1:0] OP_LOAD    = 2'd0;
    localparam logic [1:0] OP_TEXT    = 2'd1;
    localparam logic [1:0] OP_RESTART = 2'd2;

    // compare flags and-ed per group in the first reduce stage
    localparam int NSM_GROUP = 8;

    typedef struct packed {
        logic [1:0] op;
        logic [7:0] byte_value;
        logic [6:0] pattern_slot;
    } nsm_in_t;

    typedef struct packed {
        logic        match_found;
        logic [31:0] match_start;
        logic [31:0] match_total;
    } nsm_out_t;

    typedef logic [7:0] nsm_cfg_t;

    typedef struct packed {
        logic       shift;
        logic       clear;
        logic       load_eq;
        logic       rot_up;
        logic       rot_dn;
        logic [7:0] byte_value;
    } nsm_cell_ctl_t;

    typedef struct packed {
        logic        text;
        logic        restart;
        logic        guard;
        logic [31:0] start;
    } nsm_side_t;

endpackage

`default_nettype wire

### design/nsm_chan_if.sv
// valid/ready channel carrying one payload beat
`default_nettype none

interface nsm_chan_if #(
    parameter type data_t = logic
);
    logic  valid;
    logic  ready;
    data_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

### design/nsm_cell.sv
// one cell: window byte, aligned pattern byte and registered compare flag
`default_nettype none

module nsm_cell (
    input  logic                   clk,
    input  logic                   rst_n,
    input  nsm_pkg::nsm_cell_ctl_t ctl,
    input  logic                   active,
    input  logic                   pat_wr,
    input  logic [7:0]             win_in,
    input  logic [7:0]             pat_prev,
    input  logic [7:0]             pat_nxt,
    output logic [7:0]             win_out,
    output logic [7:0]             pat_out,
    output logic                   eq
);
    import nsm_pkg::*;

    logic [7:0] win_reg;
    logic [7:0] win_next;
    logic [7:0] pat_reg;
    logic [7:0] pat_next;
    logic       eq_reg;

    always_comb
    begin
        win_next = win_reg;
        if (ctl.clear)
        begin
            win_next = 8'd0;
        end
        else if (ctl.shift)
        begin
            win_next = win_in;
        end
    end

    always_comb
    begin
        pat_next = pat_reg;
        if (pat_wr)
        begin
            pat_next = ctl.byte_value;
        end
        else if (ctl.rot_up)
        begin
            pat_next = pat_prev;
        end
        else if (ctl.rot_dn)
        begin
            pat_next = pat_nxt;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg <= 8'd0;
        end
        else
        begin
            win_reg <= win_next;
        end
    end

    // compare against the byte this cell holds after the shift
    always_ff @(posedge clk)
    begin
        pat_reg <= pat_next;
        if (ctl.load_eq)
        begin
            eq_reg <= !active || (win_in == pat_reg);
        end
    end

    assign win_out = win_reg;
    assign pat_out = pat_reg;
    assign eq      = eq_reg;

endmodule

`default_nettype wire

### design/nsm_reduce.sv
// registered first level of the and-tree over the cell compare flags
`default_nettype none

module nsm_reduce #(
    parameter int WIDTH = 128
) (
    input  logic                                                  clk,
    input  logic                                                  en,
    input  logic [WIDTH-1:0]                                      eq_in,
    output logic [(WIDTH+nsm_pkg::NSM_GROUP-1)/nsm_pkg::NSM_GROUP-1:0] part
);
    import nsm_pkg::*;

    localparam int NG = (WIDTH + NSM_GROUP - 1) / NSM_GROUP;

    logic [NG*NSM_GROUP-1:0] pad;
    logic [NG-1:0]           part_next;
    logic [NG-1:0]           part_reg;

    always_comb
    begin
        pad = '1;
        pad[WIDTH-1:0] = eq_in;
        for (int g = 0; g < NG; g++)
        begin
            part_next[g] = &pad[g*NSM_GROUP +: NSM_GROUP];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            part_reg <= part_next;
        end
    end

    assign part = part_reg;

endmodule

`default_nettype wire

### design/naive_string_matcher_unit.sv
// Streaming brute-force string matcher, top level.
// req carries one item per beat: op 0 loads byte_value into pattern_slot,
// op 1 feeds one text byte, op 2 restarts the text (window, position and
// count cleared; pattern and length kept); op 3 does nothing.
// rsp returns exactly one beat per item: match_found and match_start tell
// whether and where the pattern ends at that text byte, match_total is the
// saturating count since restart. cfg writes pattern_length (0 acts as 1,
// above PATTERN_MAX acts as PATTERN_MAX) and is always ready.
// A row of PATTERN_MAX cells shifts the text window and compares every
// position at once; flags are and-ed over two registered stages, so a
// result passes the cell compare, group and result registers, one item per
// clock while rsp is ready and the ring is not rotating. The cells hold the
// pattern rotated to match the length in use: after a length change
// req.ready stays low while the ring rotates one step per clock.
// Reset clears window, position, count and sets the length to 1; pattern
// bytes are undefined until loaded. A stalled rsp holds its beat; each
// stage keeps taking items until the one ahead of it is full.
`default_nettype none

module naive_string_matcher_unit #(
    parameter int PATTERN_MAX = 128
) (
    input  logic       clk,
    input  logic       rst_n,
    nsm_chan_if.sink   req,
    nsm_chan_if.source rsp,
    nsm_chan_if.sink   cfg
);
    import nsm_pkg::*;

    localparam int IW = $clog2(PATTERN_MAX);
    localparam int LW = $clog2(PATTERN_MAX + 1);
    localparam int UW = $clog2(2 * PATTERN_MAX + 128);
    localparam int NG = (PATTERN_MAX + NSM_GROUP - 1) / NSM_GROUP;

    logic [7:0]    cfg_len_reg;
    logic [LW-1:0] len_reg;
    logic [LW-1:0] len_next;
    logic [LW-1:0] tgt_len;
    logic          rotating;
    logic          rot_up;
    logic          rot_dn;

    logic          acc;
    logic          rdy_a;
    logic          rdy_b;
    logic          rdy_c;
    logic          is_load;
    logic          is_text;
    logic          is_restart;
    logic          slot_ok;
    logic [UW-1:0] wr_sum;
    logic [UW-1:0] wr_wrap;
    logic [IW-1:0] wr_idx;

    logic [31:0]   pos_reg;
    logic [31:0]   pos_next;
    logic [31:0]   len_m1;

    logic          va_reg;
    logic          vb_reg;
    logic          out_v_reg;
    nsm_side_t     side_a_next;
    nsm_side_t     side_a_reg;
    nsm_side_t     side_b_reg;
    nsm_out_t      out_reg;
    nsm_out_t      out_next;
    logic [31:0]   cnt_reg;
    logic [31:0]   cnt_next;
    logic          hit;

    nsm_cell_ctl_t      ctl;
    logic [7:0]         win   [PATTERN_MAX];
    logic [7:0]         pat   [PATTERN_MAX];
    logic [PATTERN_MAX-1:0] eq;
    logic [PATTERN_MAX-1:0] act;
    logic [PATTERN_MAX-1:0] wr_en;
    logic [NG-1:0]      part_b;

    // length clamp and ring rotation toward it
    always_comb
    begin
        if (cfg_len_reg == 8'd0)
        begin
            tgt_len = LW'(1);
        end
        else if (int'(cfg_len_reg) > PATTERN_MAX)
        begin
            tgt_len = LW'(PATTERN_MAX);
        end
        else
        begin
            tgt_len = LW'(cfg_len_reg);
        end
    end

    assign rotating = (len_reg != tgt_len);
    assign rot_up   = rotating && (tgt_len > len_reg);
    assign rot_dn   = rotating && (tgt_len < len_reg);

    always_comb
    begin
        len_next = len_reg;
        if (rot_up)
        begin
            len_next = len_reg + LW'(1);
        end
        else if (rot_dn)
        begin
            len_next = len_reg - LW'(1);
        end
    end

    // pipeline handshake
    assign rdy_c     = !out_v_reg || rsp.ready;
    assign rdy_b     = !vb_reg || rdy_c;
    assign rdy_a     = !va_reg || rdy_b;
    assign req.ready = rdy_a && !rotating;
    assign cfg.ready = 1'b1;
    assign acc       = req.valid && req.ready;

    always_comb
    begin
        is_load    = 1'b0;
        is_text    = 1'b0;
        is_restart = 1'b0;
        unique case (req.data.op)
            OP_LOAD:    is_load    = 1'b1;
            OP_TEXT:    is_text    = 1'b1;
            OP_RESTART: is_restart = 1'b1;
            default:    ;
        endcase
    end

    // slot s sits in cell (len - 1 - s) mod PATTERN_MAX
    assign slot_ok = int'(req.data.pattern_slot) < PATTERN_MAX;
    assign wr_sum  = UW'(len_reg) + UW'(PATTERN_MAX) - UW'(1)
                     - UW'(req.data.pattern_slot);
    assign wr_wrap = (wr_sum >= UW'(PATTERN_MAX)) ? (wr_sum - UW'(PATTERN_MAX)) : wr_sum;
    assign wr_idx  = wr_wrap[IW-1:0];

    assign ctl.shift      = acc && is_text;
    assign ctl.clear      = acc && is_restart;
    assign ctl.load_eq    = acc;
    assign ctl.rot_up     = rot_up;
    assign ctl.rot_dn     = rot_dn;
    assign ctl.byte_value = req.data.byte_value;

    genvar k;
    generate
        for (k = 0; k < PATTERN_MAX; k++)
        begin : g_cell
            logic [7:0] win_src;

            assign act[k]   = k < int'(len_reg);
            assign wr_en[k] = acc && is_load && slot_ok && (wr_idx == IW'(k));

            if (k == 0)
            begin : g_head
                assign win_src = req.data.byte_value;
            end
            else
            begin : g_body
                assign win_src = win[k-1];
            end

            nsm_cell u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .ctl      (ctl),
                .active   (act[k]),
                .pat_wr   (wr_en[k]),
                .win_in   (win_src),
                .pat_prev (pat[(k + PATTERN_MAX - 1) % PATTERN_MAX]),
                .pat_nxt  (pat[(k + 1) % PATTERN_MAX]),
                .win_out  (win[k]),
                .pat_out  (pat[k]),
                .eq       (eq[k])
            );
        end
    endgenerate

    nsm_reduce #(
        .WIDTH (PATTERN_MAX)
    ) u_reduce (
        .clk   (clk),
        .en    (rdy_b && va_reg),
        .eq_in (eq),
        .part  (part_b)
    );

    // text position and sideband at acceptance
    assign len_m1 = 32'(len_reg) - 32'd1;

    always_comb
    begin
        side_a_next.text    = is_text;
        side_a_next.restart = is_restart;
        side_a_next.guard   = pos_reg >= len_m1;
        side_a_next.start   = pos_reg - len_m1;
        pos_next = pos_reg;
        if (is_text && (pos_reg != '1))
        begin
            pos_next = pos_reg + 32'd1;
        end
        else if (is_restart)
        begin
            pos_next = 32'd0;
        end
    end

    // final stage: and of groups, count, result beat
    always_comb
    begin
        hit      = side_b_reg.text && side_b_reg.guard && (&part_b);
        cnt_next = cnt_reg;
        if (side_b_reg.restart)
        begin
            cnt_next = 32'd0;
        end
        else if (hit && (cnt_reg != '1))
        begin
            cnt_next = cnt_reg + 32'd1;
        end
        out_next.match_found = hit;
        out_next.match_start = hit ? side_b_reg.start : 32'd0;
        out_next.match_total = cnt_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_len_reg <= 8'd1;
            len_reg     <= LW'(1);
            pos_reg     <= 32'd0;
            cnt_reg     <= 32'd0;
            va_reg      <= 1'b0;
            vb_reg      <= 1'b0;
            out_v_reg   <= 1'b0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                cfg_len_reg <= cfg.data;
            end
            len_reg <= len_next;
            if (acc)
            begin
                pos_reg <= pos_next;
            end
            if (rdy_a)
            begin
                va_reg <= acc;
            end
            if (rdy_b)
            begin
                vb_reg <= va_reg;
            end
            if (rdy_c)
            begin
                out_v_reg <= vb_reg;
                if (vb_reg)
                begin
                    cnt_reg <= cnt_next;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            side_a_reg <= side_a_next;
        end
        if (rdy_b && va_reg)
        begin
            side_b_reg <= side_a_reg;
        end
        if (rdy_c && vb_reg)
        begin
            out_reg <= out_next;
        end
    end

    assign rsp.valid = out_v_reg;
    assign rsp.data  = out_reg;

    // a reported match is always counted
    a_found_counted: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.data.match_found |-> rsp.data.match_total != 32'd0)
        else $error("match reported with zero total");

    // only a restart lowers the count
    a_count_monotone: assert property (@(posedge clk) disable iff (!rst_n)
        vb_reg && rdy_c && !side_b_reg.restart |=> cnt_reg >= $past(cnt_reg))
        else $error("match count dropped without restart");

    // the aligned length moves only while the ring rotates
    a_len_moves: assert property (@(posedge clk) disable iff (!rst_n)
        len_reg != $past(len_reg) |-> $past(rotating))
        else $error("aligned length changed outside rotation");

    // a stage holding an item keeps it while the next stage is full
    a_stage_hold: assert property (@(posedge clk) disable iff (!rst_n)
        va_reg && !rdy_b |=> va_reg && $stable(side_a_reg))
        else $error("stage a item lost under stall");

    // text position saturates
    a_pos_sat: assert property (@(posedge clk) disable iff (!rst_n)
        acc && is_text && (pos_reg == '1) |=> pos_reg == '1)
        else $error("text position wrapped");

endmodule

`default_nettype wire
